/* rtl/mpe_pkg.sv */
// ----------------------------------------------------------------------------
// mpe_pkg
// Shared types and constants of the MessagePack item header encoder.
// ----------------------------------------------------------------------------
package mpe_pkg;

  typedef enum logic [3:0] {
    CMD_NIL   = 4'd0,
    CMD_BOOL  = 4'd1,
    CMD_INT   = 4'd2,
    CMD_UINT  = 4'd3,
    CMD_FLOAT = 4'd4,
    CMD_STR   = 4'd5,
    CMD_BIN   = 4'd6,
    CMD_ARRAY = 4'd7,
    CMD_MAP   = 4'd8,
    CMD_EXT   = 4'd9,
    CMD_RAW   = 4'd10
  } cmd_e;

  // Encoded sequence: up to nine bytes, first byte in the top lane
  localparam int unsigned SeqBytes = 9;
  localparam int unsigned SeqBits  = SeqBytes * 8;
  localparam int unsigned QDepth   = 2;

  typedef struct packed {
    logic [SeqBits-1:0] bytes;
    logic [3:0]         cnt;    // 1..9
  } seq_t;

  localparam logic [7:0] PFX_NIL    = 8'hc0;
  localparam logic [7:0] PFX_FALSE  = 8'hc2;
  localparam logic [7:0] PFX_TRUE   = 8'hc3;
  localparam logic [7:0] PFX_BIN8   = 8'hc4;
  localparam logic [7:0] PFX_BIN16  = 8'hc5;
  localparam logic [7:0] PFX_BIN32  = 8'hc6;
  localparam logic [7:0] PFX_EXT8   = 8'hc7;
  localparam logic [7:0] PFX_EXT16  = 8'hc8;
  localparam logic [7:0] PFX_EXT32  = 8'hc9;
  localparam logic [7:0] PFX_FLOAT  = 8'hcb;
  localparam logic [7:0] PFX_UINT8  = 8'hcc;
  localparam logic [7:0] PFX_UINT16 = 8'hcd;
  localparam logic [7:0] PFX_UINT32 = 8'hce;
  localparam logic [7:0] PFX_UINT64 = 8'hcf;
  localparam logic [7:0] PFX_INT8   = 8'hd0;
  localparam logic [7:0] PFX_INT16  = 8'hd1;
  localparam logic [7:0] PFX_INT32  = 8'hd2;
  localparam logic [7:0] PFX_INT64  = 8'hd3;
  localparam logic [7:0] PFX_FEXT1  = 8'hd4;
  localparam logic [7:0] PFX_FEXT2  = 8'hd5;
  localparam logic [7:0] PFX_FEXT4  = 8'hd6;
  localparam logic [7:0] PFX_FEXT8  = 8'hd7;
  localparam logic [7:0] PFX_FEXT16 = 8'hd8;
  localparam logic [7:0] PFX_STR8   = 8'hd9;
  localparam logic [7:0] PFX_STR16  = 8'hda;
  localparam logic [7:0] PFX_STR32  = 8'hdb;
  localparam logic [7:0] PFX_ARR16  = 8'hdc;
  localparam logic [7:0] PFX_ARR32  = 8'hdd;
  localparam logic [7:0] PFX_MAP16  = 8'hde;
  localparam logic [7:0] PFX_MAP32  = 8'hdf;
  localparam logic [7:0] PFX_FIXMAP = 8'h80;
  localparam logic [7:0] PFX_FIXARR = 8'h90;
  localparam logic [7:0] PFX_FIXSTR = 8'ha0;

endpackage

/* rtl/mpe_front.sv */
// ----------------------------------------------------------------------------
// mpe_front
// Accepts commands, picks the encoding form and registers the full byte
// sequence of the item.
// ----------------------------------------------------------------------------
module mpe_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         command_i,
  input  logic [63:0]        value_i,
  input  logic [31:0]        length_i,
  input  logic signed [7:0]  ext_type_i,
  output logic               seq_valid_o,
  output mpe_pkg::seq_t      seq_o,
  input  logic               seq_ready_i
);
  import mpe_pkg::*;

  logic        vld_q, vld_d;
  seq_t        seq_q, seq_d;
  logic        take;
  logic        known;
  logic [7:0]  hdr;
  logic [63:0] payload;
  logic [3:0]  plen;
  logic [3:0]  sh;
  logic [63:0] payload_l;
  logic        len_le8, len_le16;
  logic        fit_fix, fit8, fit16, fit32;

  assign len_le8  = (length_i[31:8] == '0);
  assign len_le16 = (length_i[31:16] == '0);

  // Signed fits: the bits above the field all match its sign bit
  assign fit_fix = (value_i[63:7] == '0) || (value_i[63:5] == '1);
  assign fit8    = (value_i[63:7] == '0) || (value_i[63:7] == '1);
  assign fit16   = (value_i[63:15] == '0) || (value_i[63:15] == '1);
  assign fit32   = (value_i[63:31] == '0) || (value_i[63:31] == '1);

  always_comb begin
    known   = 1'b1;
    hdr     = PFX_NIL;
    payload = '0;
    plen    = 4'd0;
    unique case (command_i)
      CMD_NIL: begin
        hdr = PFX_NIL;
      end
      CMD_BOOL: begin
        hdr = value_i[0] ? PFX_TRUE : PFX_FALSE;
      end
      CMD_INT: begin
        payload = value_i;
        if (fit_fix) begin
          hdr = value_i[7:0];
        end else if (fit8) begin
          hdr = PFX_INT8;
          plen = 4'd1;
        end else if (fit16) begin
          hdr = PFX_INT16;
          plen = 4'd2;
        end else if (fit32) begin
          hdr = PFX_INT32;
          plen = 4'd4;
        end else begin
          hdr = PFX_INT64;
          plen = 4'd8;
        end
      end
      CMD_UINT: begin
        payload = value_i;
        if (value_i[63:7] == '0) begin
          hdr = value_i[7:0];
        end else if (value_i[63:8] == '0) begin
          hdr = PFX_UINT8;
          plen = 4'd1;
        end else if (value_i[63:16] == '0) begin
          hdr = PFX_UINT16;
          plen = 4'd2;
        end else if (value_i[63:32] == '0) begin
          hdr = PFX_UINT32;
          plen = 4'd4;
        end else begin
          hdr = PFX_UINT64;
          plen = 4'd8;
        end
      end
      CMD_FLOAT: begin
        hdr     = PFX_FLOAT;
        payload = value_i;
        plen    = 4'd8;
      end
      CMD_STR: begin
        payload = {32'd0, length_i};
        if (length_i[31:5] == '0) begin
          hdr = PFX_FIXSTR | length_i[7:0];
        end else if (len_le8) begin
          hdr = PFX_STR8;
          plen = 4'd1;
        end else if (len_le16) begin
          hdr = PFX_STR16;
          plen = 4'd2;
        end else begin
          hdr = PFX_STR32;
          plen = 4'd4;
        end
      end
      CMD_BIN: begin
        payload = {32'd0, length_i};
        if (len_le8) begin
          hdr = PFX_BIN8;
          plen = 4'd1;
        end else if (len_le16) begin
          hdr = PFX_BIN16;
          plen = 4'd2;
        end else begin
          hdr = PFX_BIN32;
          plen = 4'd4;
        end
      end
      CMD_ARRAY, CMD_MAP: begin
        payload = {32'd0, length_i};
        if (length_i[31:4] == '0) begin
          hdr = ((command_i == CMD_ARRAY) ? PFX_FIXARR : PFX_FIXMAP) | length_i[7:0];
        end else if (len_le16) begin
          hdr = (command_i == CMD_ARRAY) ? PFX_ARR16 : PFX_MAP16;
          plen = 4'd2;
        end else begin
          hdr = (command_i == CMD_ARRAY) ? PFX_ARR32 : PFX_MAP32;
          plen = 4'd4;
        end
      end
      CMD_EXT: begin
        // Length bytes then the type byte, which always closes the item
        payload = {24'd0, length_i, ext_type_i};
        priority if (length_i == 32'd1) begin
          hdr = PFX_FEXT1;
          plen = 4'd1;
        end else if (length_i == 32'd2) begin
          hdr = PFX_FEXT2;
          plen = 4'd1;
        end else if (length_i == 32'd4) begin
          hdr = PFX_FEXT4;
          plen = 4'd1;
        end else if (length_i == 32'd8) begin
          hdr = PFX_FEXT8;
          plen = 4'd1;
        end else if (length_i == 32'd16) begin
          hdr = PFX_FEXT16;
          plen = 4'd1;
        end else if (len_le8) begin
          hdr = PFX_EXT8;
          plen = 4'd2;
        end else if (len_le16) begin
          hdr = PFX_EXT16;
          plen = 4'd3;
        end else begin
          hdr = PFX_EXT32;
          plen = 4'd5;
        end
      end
      CMD_RAW: begin
        hdr = value_i[7:0];
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Left-align the payload below the header byte
  assign sh        = 4'd8 - plen;
  assign payload_l = payload << {sh, 3'b000};

  assign in_stall_o = vld_q && !seq_ready_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    seq_d = seq_q;
    if (vld_q && seq_ready_i) begin
      vld_d = 1'b0;
    end
    if (take) begin
      // drop unknown commands: accepted, nothing emitted
      vld_d     = known;
      seq_d.bytes = {hdr, payload_l};
      seq_d.cnt   = plen + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q <= seq_d;
  end

  assign seq_valid_o = vld_q;
  assign seq_o       = seq_q;

endmodule

/* rtl/mpe_queue.sv */
// ----------------------------------------------------------------------------
// mpe_queue
// Short queue of encoded sequences between the front and the serialiser.
// ----------------------------------------------------------------------------
module mpe_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  mpe_pkg::seq_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output mpe_pkg::seq_t pop_data_o
);
  import mpe_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  seq_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/mpe_back.sv */
// ----------------------------------------------------------------------------
// mpe_back
// Serialiser: shifts one encoded sequence out a byte per unstalled cycle,
// flags the final byte and loads the next sequence without a gap.
// ----------------------------------------------------------------------------
module mpe_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          seq_valid_i,
  output logic          seq_pop_o,
  input  mpe_pkg::seq_t seq_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic          last_o
);
  import mpe_pkg::*;

  logic               busy_q, busy_d;
  logic [SeqBits-1:0] word_q, word_d;
  logic [3:0]         cnt_q, cnt_d;
  logic               take, fin, load;

  assign take = busy_q && !out_stall_i;
  assign fin  = (cnt_q == 4'd1);
  assign load = seq_valid_i && (!busy_q || (take && fin));

  always_comb begin
    busy_d = busy_q;
    word_d = word_q;
    cnt_d  = cnt_q;
    if (load) begin
      busy_d = 1'b1;
      word_d = seq_i.bytes;
      cnt_d  = seq_i.cnt;
    end else if (take) begin
      // advance to the next byte, or go idle after the final one
      if (fin) begin
        busy_d = 1'b0;
      end
      word_d = {word_q[SeqBits-9:0], 8'd0};
      cnt_d  = cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign seq_pop_o   = load;
  assign out_valid_o = busy_q;
  assign out_byte_o  = word_q[SeqBits-1 -: 8];
  assign last_o      = fin;

endmodule

/* rtl/msgpack_item_header_encoder.sv */
// ----------------------------------------------------------------------------
// msgpack_item_header_encoder
// Encodes one command per item into its MessagePack byte sequence.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with command, value, length and
// ext_type; an item is taken on a clock edge with valid high and stall low.
// Commands 11 to 15 are taken and produce no bytes.
// Output channel: out_valid_o / out_stall_i with one byte per item on that
// channel; last_o marks the final byte of each command's sequence.
// Path: classifier register, then the queue, then the serialiser register.
// Throughput: one byte per cycle while out_stall_i is low; a command's
// sequence is 1 to 9 bytes (header byte plus up to eight data bytes).
// Commands are taken one per cycle while the two-entry queue between the
// classifier register and the serialiser has room; sequences follow each
// other on the output with no idle cycle.
// A stall on the output holds the current byte; once the queue and the
// classifier register fill, in_stall_o rises.
// Reset empties the register, the queue and the serialiser; nothing else.
// ----------------------------------------------------------------------------
module msgpack_item_header_encoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [3:0]        command_i,
  input  logic [63:0]       value_i,
  input  logic [31:0]       length_i,
  input  logic signed [7:0] ext_type_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              last_o
);
  import mpe_pkg::*;

  logic f_valid, q_ready, q_valid, q_pop;
  seq_t f_seq, q_seq;

  mpe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .value_i     (value_i),
    .length_i    (length_i),
    .ext_type_i  (ext_type_i),
    .seq_valid_o (f_valid),
    .seq_o       (f_seq),
    .seq_ready_i (q_ready)
  );

  mpe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (q_ready),
    .push_data_i  (f_seq),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_seq)
  );

  mpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seq_valid_i (q_valid),
    .seq_pop_o   (q_pop),
    .seq_i       (q_seq),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule
